// ===== design/rwg_pkg.sv =====
// types and constants shared by the ricker wavelet generator
// no dependencies
package rwg_pkg;

  typedef enum logic [1:0] {
    CFG_SAMPLE_COUNT = 2'd0,
    CFG_SAMPLE_STEP  = 2'd1,
    CFG_PEAK_FREQ    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;
  localparam logic [63:0] ROUND_HALF = 64'd4398046511104;
  localparam int unsigned SERIES_TERMS = 10;

  // floor(2^32 / n), entry 0 unused
  localparam logic [32:0] RECIP [0:10] = '{
    33'd0, 33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459, 33'd715827882, 33'd613566756, 33'd536870912,
    33'd477218588, 33'd429496729
  };

  // request state after the front end
  typedef struct packed {
    logic        oor;
    logic        flush;
    logic        neg;
    logic [34:0] wm;
    logic [29:0] x;
    logic [30:0] r;
  } work_t;

endpackage

// ===== design/rwg_if.sv =====
// stream channels of the ricker wavelet generator
// no dependencies
interface rwg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_index;
  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface rwg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;
  logic        out_of_range;
  modport source (output valid, output sample_value, output out_of_range, input ready);
  modport sink (input valid, input sample_value, input out_of_range, output ready);
endinterface

// ===== design/rwg_front.sv =====
// front end: time argument, range check, flush test, a = (pi f t)^2, |1 - 2a| and a/16
// depends on rwg_pkg
module rwg_front #(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [15:0]         idx,
  input  logic [16:0]         sample_count,
  input  logic [31:0]         sample_step,
  input  logic [9:0]          peak_freq,
  output logic                out_vld,
  output rwg_pkg::work_t      out_work
);
  import rwg_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned LW    = (CNT_W > 17) ? CNT_W : 17;

  logic [LW-1:0] cnt_ext, lim;
  logic          oor_now;

  logic        v1, v2, v3, v4, v5, v6;
  logic        oor1, oor2, oor3, oor4, oor5;
  logic        fl3, fl4, fl5;
  logic [25:0] p1;
  logic [57:0] u2;
  logic [30:0] d3;
  logic [32:0] argm4;
  logic [33:0] a5;
  work_t       w6, w6_next;

  logic [57:0] d_full;
  logic [62:0] argm_prod;
  logic [63:0] a_sq;
  logic [34:0] two_a;

  assign cnt_ext = LW'(sample_count);
  assign lim     = (cnt_ext > LW'(MAX_SAMPLES)) ? LW'(MAX_SAMPLES) : cnt_ext;
  assign oor_now = LW'(idx) >= lim;

  assign d_full    = (u2 >= 58'(TWO_PI_Q32)) ? (u2 - 58'(TWO_PI_Q32))
                                              : (58'(TWO_PI_Q32) - u2);
  assign argm_prod = 63'(d3 * PI_Q30);
  assign a_sq      = argm4[31:0] * argm4[31:0];
  assign two_a     = {a5, 1'b0};

  always_comb begin
    w6_next.oor   = oor5;
    w6_next.flush = fl5;
    w6_next.neg   = two_a > 35'(Q30_ONE);
    w6_next.wm    = (two_a > 35'(Q30_ONE)) ? (two_a - 35'(Q30_ONE))
                                           : (35'(Q30_ONE) - two_a);
    w6_next.x     = a5[33:4];
    w6_next.r     = Q30_ONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1    <= idx * peak_freq;
      oor1  <= oor_now;
      u2    <= p1 * sample_step;
      oor2  <= oor1;
      d3    <= d_full[32:2];
      fl3   <= d_full[57:33] != '0;
      oor3  <= oor2;
      // pi in Q2.30, product back to Q.30
      argm4 <= argm_prod[62:30];
      fl4   <= fl3;
      oor4  <= oor3;
      a5    <= a_sq[63:30];
      fl5   <= fl4 | argm4[32];
      oor5  <= oor4;
      w6    <= w6_next;
    end
  end

  assign out_vld  = v6;
  assign out_work = w6;
endmodule

// ===== design/rwg_horner.sv =====
// one term of the exp series: r = 1 - floor((x*r >> 30) / n), three stages
// depends on rwg_pkg
module rwg_horner #(
  parameter int unsigned DIVISOR = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  rwg_pkg::work_t in_work,
  output logic           out_vld,
  output rwg_pkg::work_t out_work
);
  import rwg_pkg::*;

  logic        v1, v2, v3;
  work_t       w1, w2, w3, w3_next;
  logic [29:0] t1, t2, q2;
  logic [60:0] xr;
  logic [62:0] tm;
  logic [33:0] q0n, rem;
  logic [30:0] q;

  assign xr  = in_work.x * in_work.r;
  assign tm  = t1 * RECIP[DIVISOR];
  assign q0n = 34'(q2) * 34'(DIVISOR);
  assign rem = 34'(t2) - q0n;
  // reciprocal estimate is at most one low
  assign q   = (rem >= 34'(DIVISOR)) ? (31'(q2) + 31'd1) : 31'(q2);

  always_comb begin
    w3_next   = w2;
    w3_next.r = Q30_ONE - q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld; v2 <= v1; v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= in_work;
      t1 <= xr[59:30];
      w2 <= w1;
      t2 <= t1;
      q2 <= tm[61:32];
      w3 <= w3_next;
    end
  end

  assign out_vld  = v3;
  assign out_work = w3;
endmodule

// ===== design/rwg_square.sv =====
// one squaring stage, r = r*r >> 30
// depends on rwg_pkg
module rwg_square (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  rwg_pkg::work_t in_work,
  output logic           out_vld,
  output rwg_pkg::work_t out_work
);
  import rwg_pkg::*;

  logic        v;
  work_t       w, w_next;
  logic [61:0] rr;

  assign rr = in_work.r * in_work.r;

  always_comb begin
    w_next   = in_work;
    w_next.r = rr[60:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w <= w_next;
    end
  end

  assign out_vld  = v;
  assign out_work = w;
endmodule

// ===== design/rwg_back.sv =====
// back end: (1 - 2a) * exp(-a), rounding to q1.15 and saturation, zero when out of range or flushed
// depends on rwg_pkg
module rwg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  rwg_pkg::work_t in_work,
  output logic           out_vld,
  output logic [15:0]    sample_value,
  output logic           out_of_range
);
  import rwg_pkg::*;

  logic        v1, v2;
  logic        oor1, fl1, neg1;
  logic [63:0] prod1, rnd;
  logic [20:0] mag;
  logic [15:0] val;

  assign rnd = prod1 + ROUND_HALF;
  assign mag = rnd[63:43];

  always_comb begin
    if (oor1 || fl1) begin
      val = '0;
    end else if (!neg1) begin
      val = (mag > 21'd32767) ? 16'd32767 : mag[15:0];
    end else if (mag > 21'd32768) begin
      val = 16'h8000;
    end else begin
      val = 16'(17'h10000 - mag[16:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld; v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1        <= in_work.wm * in_work.r[30:2];
      oor1         <= in_work.oor;
      fl1          <= in_work.flush;
      neg1         <= in_work.neg;
      sample_value <= val;
      out_of_range <= oor1;
    end
  end

  assign out_vld = v2;
endmodule

// ===== design/ricker_wavelet_generator.sv =====
// ricker wavelet generator top level: registers, pipeline and handshake
// depends on rwg_pkg, rwg_if, rwg_front, rwg_horner, rwg_square, rwg_back
//
// idx_ch carries request sample indexes, wave_ch returns one sample per
// request, in order: a signed q1.15 value and an out_of_range flag.
// configuration is a write port: cfg_write, cfg_index (0 sample_count,
// 1 sample_step, 2 peak_freq, 3 ignored) and cfg_data. the user must write
// it only while no request is in flight; the block does not enforce this.
// throughput is one request per cycle unless the receiver stalls. the
// pipeline has six front stages, three per exp series term over ten terms,
// four squarings and two back stages, the last being the output register.
// reset clears the pipeline and loads sample_count 1000, sample_step
// 4294967 and peak_freq 25.
// when the receiver stalls with a sample waiting, the whole pipeline holds
// and idx_ch.ready drops; nothing is lost or repeated.
module ricker_wavelet_generator #(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  rwg_in_if.sink            idx_ch,
  rwg_out_if.source         wave_ch
);
  import rwg_pkg::*;

  logic [16:0] sample_count;
  logic [31:0] sample_step;
  logic [9:0]  peak_freq;
  logic        adv;

  logic  vld [0:SERIES_TERMS+4];
  work_t wrk [0:SERIES_TERMS+4];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= 17'd1000;
      sample_step  <= 32'd4294967;
      peak_freq    <= 10'd25;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_COUNT: sample_count <= 17'(cfg_data);
        CFG_SAMPLE_STEP:  sample_step  <= cfg_data;
        CFG_PEAK_FREQ:    peak_freq    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign adv          = !wave_ch.valid || wave_ch.ready;
  assign idx_ch.ready = adv;

  rwg_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst, .adv,
    .in_vld(idx_ch.valid), .idx(idx_ch.sample_index),
    .sample_count, .sample_step, .peak_freq,
    .out_vld(vld[0]), .out_work(wrk[0])
  );

  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    rwg_horner #(.DIVISOR(SERIES_TERMS - k)) u_term (
      .clk, .rst, .adv,
      .in_vld(vld[k]), .in_work(wrk[k]),
      .out_vld(vld[k+1]), .out_work(wrk[k+1])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_sq
    rwg_square u_sq (
      .clk, .rst, .adv,
      .in_vld(vld[SERIES_TERMS+k]), .in_work(wrk[SERIES_TERMS+k]),
      .out_vld(vld[SERIES_TERMS+k+1]), .out_work(wrk[SERIES_TERMS+k+1])
    );
  end

  rwg_back u_back (
    .clk, .rst, .adv,
    .in_vld(vld[SERIES_TERMS+4]), .in_work(wrk[SERIES_TERMS+4]),
    .out_vld(wave_ch.valid),
    .sample_value(wave_ch.sample_value),
    .out_of_range(wave_ch.out_of_range)
  );
endmodule
